// ===== hdl/udkc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package udkc_pkg;

  // widths fixed by the item and register formats
  localparam int unsigned NowWidth        = 32;
  localparam int unsigned CfgWidth        = 16;
  localparam int unsigned CfgIndexWidth   = 2;
  localparam int unsigned TimeBitsDefault = 32;

  // register reset values
  localparam logic [CfgWidth-1:0] UpdownDebounceReset = 16'd50;
  localparam logic [CfgWidth-1:0] PressDebounceReset  = 16'd50;
  localparam logic [CfgWidth-1:0] LongPressReset      = 16'd500;
  localparam logic [CfgWidth-1:0] RepeatIntervalReset = 16'd300;

  // item opcodes
  typedef enum logic [1:0] {
    OP_POLL       = 2'd0,
    OP_PRESS_EDGE = 2'd1,
    OP_UP_EDGE    = 2'd2,
    OP_DOWN_EDGE  = 2'd3
  } op_e;

  // latched key, same encoding as the edge opcodes
  typedef enum logic [1:0] {
    KEY_NONE  = 2'd0,
    KEY_PRESS = 2'd1,
    KEY_UP    = 2'd2,
    KEY_DOWN  = 2'd3
  } key_e;

  // result event kinds
  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_PRESS      = 3'd1,
    EV_PRESS_LONG = 3'd2,
    EV_UP         = 3'd3,
    EV_UP_LONG    = 3'd4,
    EV_DOWN       = 3'd5,
    EV_DOWN_LONG  = 3'd6
  } event_e;

  // register indexes
  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_UPDOWN_DEBOUNCE = 2'd0,
    CFG_PRESS_DEBOUNCE  = 2'd1,
    CFG_LONG_PRESS      = 2'd2,
    CFG_REPEAT_INTERVAL = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [CfgWidth-1:0] updown_debounce;
    logic [CfgWidth-1:0] press_debounce;
    logic [CfgWidth-1:0] long_press;
    logic [CfgWidth-1:0] repeat_interval;
  } cfg_t;

  // per key status after a poll
  typedef struct packed {
    logic active_d;
    logic short_ev;
    logic long_ev;
  } key_stat_t;

endpackage

`default_nettype wire

// ===== hdl/updown_press_key_classifier.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   | handshake                  | payload
// ----------+----------------------------+----------------------------------------
// input     | in_valid_i / in_ready_o    | op_i, now_ms_i, press_held_i, up_held_i,
//           |                            | down_held_i
// output    | out_valid_o / out_ready_i  | event_kind_o
// config    | cfg_we_i                   | cfg_index_i, cfg_data_i
//
// an item waits in the input register; key state and the result register are updated
// when it advances, one item per cycle while no pending result stalls it
// the per-key hold and debounce logic lies between the input register and those registers
// reset clears the latch, all key timers and loads the register defaults
// a pending result stalls the input register; input stays ready while it drains

module updown_press_key_classifier #(
  parameter int unsigned TIME_BITS = udkc_pkg::TimeBitsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          op_i,
  input  logic [udkc_pkg::NowWidth-1:0]       now_ms_i,
  input  logic                                press_held_i,
  input  logic                                up_held_i,
  input  logic                                down_held_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [2:0]                          event_kind_o,
  input  logic                                cfg_we_i,
  input  logic [udkc_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  logic [udkc_pkg::CfgWidth-1:0]       cfg_data_i
);
  import udkc_pkg::*;

  cfg_t                  cfg;
  logic                  in_valid_q;
  op_e                   op_q;
  logic [NowWidth-1:0]   now_q;
  logic                  press_held_q, up_held_q, down_held_q;
  key_e                  latched_q, latched_d;
  logic                  out_valid_q;
  event_e                event_kind_q;

  logic                  out_free;
  logic                  advance;
  logic                  poll;
  logic [TIME_BITS-1:0]  now_t;
  key_stat_t             press_st, up_st, down_st;
  logic                  any_active;
  event_e                ev;

  // handshake
  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || advance;
  assign poll       = advance && (op_q == OP_POLL);
  assign now_t      = TIME_BITS'(now_q);

  udkc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q         <= op_e'(op_i);
      now_q        <= now_ms_i;
      press_held_q <= press_held_i;
      up_held_q    <= up_held_i;
      down_held_q  <= down_held_i;
    end
  end

  // one hold unit per key
  udkc_key #(.TIME_BITS(TIME_BITS), .IS_PRESS(1'b1)) u_key_press (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (poll),
    .start_i     (latched_q == KEY_PRESS && press_held_q),
    .held_i      (press_held_q),
    .now_i       (now_t),
    .debounce_i  (cfg.press_debounce),
    .long_ms_i   (cfg.long_press),
    .repeat_ms_i (cfg.repeat_interval),
    .stat_o      (press_st)
  );

  udkc_key #(.TIME_BITS(TIME_BITS), .IS_PRESS(1'b0)) u_key_up (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (poll),
    .start_i     (latched_q == KEY_UP && up_held_q),
    .held_i      (up_held_q),
    .now_i       (now_t),
    .debounce_i  (cfg.updown_debounce),
    .long_ms_i   (cfg.long_press),
    .repeat_ms_i (cfg.repeat_interval),
    .stat_o      (up_st)
  );

  udkc_key #(.TIME_BITS(TIME_BITS), .IS_PRESS(1'b0)) u_key_down (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (poll),
    .start_i     (latched_q == KEY_DOWN && down_held_q),
    .held_i      (down_held_q),
    .now_i       (now_t),
    .debounce_i  (cfg.updown_debounce),
    .long_ms_i   (cfg.long_press),
    .repeat_ms_i (cfg.repeat_interval),
    .stat_o      (down_st)
  );

  assign any_active = press_st.active_d | up_st.active_d | down_st.active_d;

  // event priority: down over up over press
  always_comb begin
    ev = EV_NONE;
    if (press_st.short_ev) ev = EV_PRESS;
    if (press_st.long_ev)  ev = EV_PRESS_LONG;
    if (up_st.short_ev)    ev = EV_UP;
    if (up_st.long_ev)     ev = EV_UP_LONG;
    if (down_st.short_ev)  ev = EV_DOWN;
    if (down_st.long_ev)   ev = EV_DOWN_LONG;
  end

  // key latch
  always_comb begin
    latched_d = latched_q;
    if (advance && op_q != OP_POLL) begin
      latched_d = key_e'(op_q);
    end else if (poll && !any_active) begin
      latched_d = KEY_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latched_q <= KEY_NONE;
    end else begin
      latched_q <= latched_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (poll && ev != EV_NONE) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (poll && ev != EV_NONE) begin
      event_kind_q <= ev;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_kind_o = event_kind_q;

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !advance)
    else $error("item advanced over a pending result");

  // only real events reach the output
  a_no_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (event_kind_q != EV_NONE))
    else $error("empty event transfer");

  // latch clears once no hold is left
  a_latch_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (poll && !any_active) |=> (latched_q == KEY_NONE))
    else $error("latch not cleared");

  // edge items give no result
  a_edge_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && op_q != OP_POLL && !out_valid_q) |=> !out_valid_q)
    else $error("edge item produced a result");

endmodule

`default_nettype wire

// ===== hdl/udkc_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module udkc_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [udkc_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  logic [udkc_pkg::CfgWidth-1:0]       cfg_data_i,
  output udkc_pkg::cfg_t                      cfg_o
);
  import udkc_pkg::*;

  cfg_t cfg_q;

  // register file, written by index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.updown_debounce <= UpdownDebounceReset;
      cfg_q.press_debounce  <= PressDebounceReset;
      cfg_q.long_press      <= LongPressReset;
      cfg_q.repeat_interval <= RepeatIntervalReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_UPDOWN_DEBOUNCE: cfg_q.updown_debounce <= cfg_data_i;
        CFG_PRESS_DEBOUNCE:  cfg_q.press_debounce  <= cfg_data_i;
        CFG_LONG_PRESS:      cfg_q.long_press      <= cfg_data_i;
        CFG_REPEAT_INTERVAL: cfg_q.repeat_interval <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hdl/udkc_key.sv =====
`timescale 1ns / 1ps
`default_nettype none

module udkc_key #(
  parameter int unsigned TIME_BITS = udkc_pkg::TimeBitsDefault,
  parameter bit          IS_PRESS  = 1'b0
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  logic                           start_i,
  input  logic                           held_i,
  input  logic [TIME_BITS-1:0]           now_i,
  input  logic [udkc_pkg::CfgWidth-1:0]  debounce_i,
  input  logic [udkc_pkg::CfgWidth-1:0]  long_ms_i,
  input  logic [udkc_pkg::CfgWidth-1:0]  repeat_ms_i,
  output udkc_pkg::key_stat_t            stat_o
);
  import udkc_pkg::*;

  logic                 active_q, active_d;
  logic [TIME_BITS-1:0] start_q, start_d;
  logic [TIME_BITS-1:0] last_short_q, last_short_d;
  logic [TIME_BITS-1:0] last_long_q, last_long_d;

  logic                 act_c;
  logic [TIME_BITS-1:0] start_c;
  logic                 timed;
  logic                 is_long;
  logic                 deb_ok;
  logic                 rep_ok;
  logic                 short_ev;
  logic                 long_ev;

  // hold start folded in before the timing checks, only when no hold is running
  assign act_c   = active_q | start_i;
  assign start_c = (start_i && !active_q) ? now_i : start_q;
  assign timed   = act_c && (start_c != '0);
  assign is_long = (now_i - start_c) >= TIME_BITS'(long_ms_i);
  assign deb_ok  = (now_i - last_short_q) >= TIME_BITS'(debounce_i);
  assign rep_ok  = (last_long_q == '0) ||
                   (!IS_PRESS && ((now_i - last_long_q) >= TIME_BITS'(repeat_ms_i)));

  // release, long hold or nothing
  always_comb begin
    active_d     = act_c;
    start_d      = start_c;
    last_short_d = last_short_q;
    last_long_d  = last_long_q;
    short_ev     = 1'b0;
    long_ev      = 1'b0;
    if (timed && !held_i) begin
      short_ev    = !is_long && deb_ok;
      active_d    = 1'b0;
      start_d     = '0;
      last_long_d = '0;
      if (short_ev) begin
        last_short_d = now_i;
      end
    end else if (timed && is_long && rep_ok) begin
      long_ev     = 1'b1;
      last_long_d = now_i;
    end
  end

  // key state, updated once per poll
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      start_q      <= '0;
      last_short_q <= '0;
      last_long_q  <= '0;
    end else if (step_i) begin
      active_q     <= active_d;
      start_q      <= start_d;
      last_short_q <= last_short_d;
      last_long_q  <= last_long_d;
    end
  end

  assign stat_o.active_d = active_d;
  assign stat_o.short_ev = short_ev;
  assign stat_o.long_ev  = long_ev;

  // a poll gives at most one event per key
  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({short_ev, long_ev}))
    else $error("key gives short and long event together");

  // a timed release ends the hold
  a_release_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && timed && !held_i) |=> (!active_q && start_q == '0))
    else $error("hold still active after release");

  // press key never repeats a long event
  a_press_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (IS_PRESS && step_i && long_ev) |=> (last_long_q != '0 || $past(now_i) == '0))
    else $error("press long event not recorded");

endmodule

`default_nettype wire
